@@ hdl/assert_macros.svh @@
// Assertion macros shared by the servo ramp controller RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/src_pkg.sv @@
// Shared types and constants for the servo ramp controller.
// No dependencies; imported by every module of the block.
package src_pkg;

    // Field widths.
    localparam int POS_W   = 8;
    localparam int CNT_W   = 8;
    localparam int DEB_W   = 2;
    localparam int IDX_W   = 8;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_UPPER_LIMIT = 8'd0;
    localparam logic [IDX_W-1:0] REG_LOWER_LIMIT = 8'd1;
    localparam logic [IDX_W-1:0] REG_RAMP_RATE   = 8'd2;
    localparam logic [IDX_W-1:0] REG_IDLE_FRAMES = 8'd3;

    // Reset values.
    localparam logic [POS_W-1:0] RESET_UPPER = 8'd170;
    localparam logic [POS_W-1:0] RESET_LOWER = 8'd80;
    localparam logic [POS_W-1:0] RESET_RATE  = 8'd2;
    localparam logic [CNT_W-1:0] RESET_IDLE  = 8'd50;

    // Pulse compare constants.
    localparam logic [7:0] PULSE_BASE = 8'd199;
    localparam logic [5:0] PULSE_SPAN = 6'd56;
    localparam logic [7:0] PULSE_OFF  = 8'd255;

    // Configuration register set.
    typedef struct packed {
        logic [POS_W-1:0] upper_limit;
        logic [POS_W-1:0] lower_limit;
        logic [POS_W-1:0] ramp_rate;
        logic [CNT_W-1:0] idle_frames;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic             request_level;
        logic [POS_W-1:0] servo_position;
        logic             relay_on;
        logic [7:0]       pwm_compare;
    } result_t;

endpackage

@@ hdl/src_cfg_regs.sv @@
// Configuration register file of the servo ramp controller.
// Depends on src_pkg for the register indexes, reset values and cfg_t.
module src_cfg_regs
    import src_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [7:0]       cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes beyond the last register are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_UPPER_LIMIT: cfg_next.upper_limit = cfg_data;
                REG_LOWER_LIMIT: cfg_next.lower_limit = cfg_data;
                REG_RAMP_RATE:   cfg_next.ramp_rate   = cfg_data;
                REG_IDLE_FRAMES: cfg_next.idle_frames = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_limit <= RESET_UPPER;
            cfg_reg.lower_limit <= RESET_LOWER;
            cfg_reg.ramp_rate   <= RESET_RATE;
            cfg_reg.idle_frames <= RESET_IDLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/src_frame_update.sv @@
// Per-frame update: debouncer, position ramp, idle countdown and pulse value.
// Depends on src_pkg and on assert_macros.svh for its checks.
`include "assert_macros.svh"

module src_frame_update
    import src_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    step_en,
    input  logic    raw_position,
    output result_t result
);

    logic             level_reg;
    logic             level_next;
    logic [DEB_W-1:0] deb_count_reg;
    logic [DEB_W-1:0] deb_count_next;
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic [CNT_W-1:0] countdown_reg;
    logic [CNT_W-1:0] countdown_next;

    logic             move_up;
    logic             move_down;
    logic [POS_W:0]   up_sum;
    logic [POS_W:0]   down_floor;
    logic [CNT_W-1:0] count_loaded;
    logic [POS_W:0]   limit_sum;
    logic [POS_W-1:0] midpoint;
    logic [13:0]      scaled;
    logic [7:0]       pwm_value;

    // Debouncer: a change is taken after four consecutive differing samples.
    always_comb
    begin
        level_next     = level_reg;
        deb_count_next = '0;
        if (raw_position != level_reg)
        begin
            deb_count_next = deb_count_reg + 1'b1;
            if (deb_count_reg == {DEB_W{1'b1}})
            begin
                level_next = raw_position;
            end
        end
    end

    // Ramp toward the requested limit, clamped at that limit.
    assign move_up    = level_next && (position_reg < cfg.upper_limit);
    assign move_down  = !level_next && (position_reg > cfg.lower_limit);
    assign up_sum     = {1'b0, position_reg} + {1'b0, cfg.ramp_rate};
    assign down_floor = {1'b0, cfg.lower_limit} + {1'b0, cfg.ramp_rate};

    always_comb
    begin
        position_next = position_reg;
        if (move_up)
        begin
            if (up_sum > {1'b0, cfg.upper_limit})
            begin
                position_next = cfg.upper_limit;
            end
            else
            begin
                position_next = up_sum[POS_W-1:0];
            end
        end
        else if (move_down)
        begin
            if ({1'b0, position_reg} >= down_floor)
            begin
                position_next = position_reg - cfg.ramp_rate;
            end
            else
            begin
                position_next = cfg.lower_limit;
            end
        end
    end

    // Idle countdown reloads on motion and counts down in the same frame.
    assign count_loaded = (move_up || move_down) ? cfg.idle_frames : countdown_reg;
    assign scaled       = {6'd0, position_next} * {8'd0, PULSE_SPAN};

    always_comb
    begin
        if (count_loaded != '0)
        begin
            countdown_next = count_loaded - 1'b1;
            pwm_value      = PULSE_BASE - {2'b00, scaled[13:8]};
        end
        else
        begin
            countdown_next = count_loaded;
            pwm_value      = PULSE_OFF;
        end
    end

    // Relay follows the position against the midpoint of the limits.
    assign limit_sum = {1'b0, cfg.lower_limit} + {1'b0, cfg.upper_limit};
    assign midpoint  = limit_sum[POS_W:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= 1'b1;
            deb_count_reg <= '0;
            position_reg  <= RESET_LOWER;
            countdown_reg <= RESET_IDLE;
        end
        else if (step_en)
        begin
            level_reg     <= level_next;
            deb_count_reg <= deb_count_next;
            position_reg  <= position_next;
            countdown_reg <= countdown_next;
        end
    end

    assign result.pwm_compare    = pwm_value;
    assign result.relay_on       = (position_next > midpoint);
    assign result.servo_position = position_next;
    assign result.request_level  = level_next;

    // State moves only when an item is processed.
    `SRC_ASSERT_NXT(a_state_holds, clk, rst_n, !step_en,
        $stable(position_reg) && $stable(countdown_reg) && $stable(level_reg))
    // The accepted level only flips when the fourth differing sample arrives.
    `SRC_ASSERT_IMP(a_level_flip, clk, rst_n, level_next != level_reg,
        deb_count_reg == {DEB_W{1'b1}})
    // With an expired countdown and no motion the pulse stays off.
    `SRC_ASSERT_IMP(a_pulse_off, clk, rst_n,
        (countdown_reg == '0) && !move_up && !move_down,
        (pwm_value == PULSE_OFF) && (countdown_next == '0))

endmodule

@@ hdl/servo_ramp_controller_core.sv @@
// Top level of the servo ramp controller: stream ports, input and result
// registers. Depends on src_pkg, src_cfg_regs and src_frame_update.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------
//   s_axis   | in        | s_tvalid/s_tready  | s_tdata: raw_position
//   m_axis   | out       | m_tvalid/m_tready  | m_tdata: pwm, relay, pos, level
//   cfg      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per clock cycle sustained while m_tready does not stall the output.
// An item passes the input register, then the result register, to m_tdata.
// The state update sits between the input register and the result register.
// A stalled result holds; the input register still takes an item whenever
// the result register is free or is being drained in the same cycle.
// Reset restores the register defaults and the power-up servo state.
module servo_ramp_controller_core
    import src_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [0] raw_position, [7:1] zero
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // [7:0] pwm_compare, [8] relay_on,
                                        // [16:9] servo_position,
                                        // [17] request_level, [23:18] zero
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [7:0]       cfg_data
);

    cfg_t    cfg;
    result_t result;
    result_t out_data_reg;
    logic    in_valid_reg;
    logic    in_raw_reg;
    logic    out_valid_reg;
    logic    advance;

    // Register file; writes are always taken.
    assign cfg_ready = 1'b1;

    src_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // An item moves on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_raw_reg <= s_tdata[0];
        end
    end

    src_frame_update u_frame_update (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step_en      (advance),
        .raw_position (in_raw_reg),
        .result       (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

endmodule
